// ===== src/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-character mapping of the Base64 encoder.
`timescale 1ns / 1ps
package b64e_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned GROUP_W = 24;
	localparam int unsigned CNT_W   = 2;

	localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'd61;   // '='
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;   // 'A'
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd97;   // 'a'
	localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'd48;   // '0'
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'd43;   // '+'
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;   // '/'

	// One 24-bit group handed from the front to the back.
	typedef struct packed {
		logic [GROUP_W-1:0] group;   // real bytes from the top, zero tail
		logic [CNT_W-1:0]   n_real;  // real bytes in the group, 1..3
		logic               last;    // group closes a message
	} group_entry_t;

	// Map a six-bit value onto the standard alphabet.
	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
		logic [CHAR_W-1:0] v7;
		v7 = {1'b0, v};
		if (v < 6'd26)
			return CHAR_UPPER + v7;
		else if (v < 6'd52)
			return CHAR_LOWER + v7 - 7'd26;
		else if (v < 6'd62)
			return CHAR_DIGIT + v7 - 7'd52;
		else if (v == 6'd62)
			return CHAR_PLUS;
		else
			return CHAR_SLASH;
	endfunction

endpackage

// ===== src/base64_stream_encoder_top.sv =====
// Top level of the streaming Base64 encoder.
`timescale 1ns / 1ps
// Usage:
//   Input side is a queue write port: present data_byte and final_byte with
//   push high; a transfer happens on a rising edge with push high and full
//   low. Mark the last byte of each message with final_byte.
//   Output side is a queue read port: while empty is low, char_code and
//   final_char hold the oldest character; a transfer happens on a rising
//   edge with pop high and empty low. final_char marks the last character
//   of an encoded message, including its '=' padding.
// Path: a closing byte's group enters the group queue, and the back then loads
//   its first character into the result register, followed by the other three.
// Throughput: the back end emits one character per cycle while pop stays high;
//   every group, full or short, gives four characters, so a short final group
//   costs as much as a full one. The group queue lets the front hold and take
//   bytes while the back drains a group.
// Reset: arst_n clears the held bytes, the queue and the result register's
//   valid flag; the block comes up empty and ready for a new message.
// Stall: when pop stays low the result register holds, the back stops, the
//   group queue fills and full rises; no character is lost or repeated.
module base64_stream_encoder_top #(
	parameter int unsigned GROUP_FIFO_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [b64e_pkg::BYTE_W-1:0] data_byte,
	input  logic                        final_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [b64e_pkg::CHAR_W-1:0] char_code,
	output logic                        final_char
);
	import b64e_pkg::*;

	group_entry_t wr_entry;
	group_entry_t rd_entry;
	logic         grp_wr;
	logic         grp_rd;
	logic         grp_full;
	logic         grp_empty;

	// Hold off the front whenever the queue cannot take another group.
	assign full = grp_full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (grp_full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.grp_wr     (grp_wr),
		.grp_entry  (wr_entry)
	);

	b64e_group_fifo #(
		.DEPTH (GROUP_FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (grp_wr),
		.wr_entry   (wr_entry),
		.rd_en      (grp_rd),
		.rd_entry   (rd_entry),
		.fifo_full  (grp_full),
		.fifo_empty (grp_empty)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp_entry  (rd_entry),
		.grp_empty  (grp_empty),
		.grp_rd     (grp_rd),
		.pop        (pop),
		.empty      (empty),
		.char_code  (char_code),
		.final_char (final_char)
	);

endmodule

// ===== src/b64e_front.sv =====
// Front end: takes bytes, holds a partial group, hands full or closing groups on.
`timescale 1ns / 1ps
module b64e_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [b64e_pkg::BYTE_W-1:0] data_byte,
	input  logic                       final_byte,
	output logic                       grp_wr,
	output b64e_pkg::group_entry_t     grp_entry
);
	import b64e_pkg::*;

	logic [CNT_W-1:0]      cnt_q;
	logic [2*BYTE_W-1:0]   held_q;
	logic [CNT_W-1:0]      cnt_eff;
	logic                  accept;

	// A count of three never occurs; treat it as two.
	assign cnt_eff = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
	assign accept  = push && !full;
	assign grp_wr  = accept && (final_byte || cnt_eff == 2'd2);

	always_comb begin
		case (cnt_eff)
			2'd0:    grp_entry.group = {data_byte, 16'h0000};
			2'd1:    grp_entry.group = {held_q[15:8], data_byte, 8'h00};
			default: grp_entry.group = {held_q, data_byte};
		endcase
		grp_entry.n_real = cnt_eff + 2'd1;
		grp_entry.last   = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (grp_wr) begin
				cnt_q  <= '0;
				held_q <= '0;
			end else begin
				cnt_q <= cnt_eff + 2'd1;
				if (cnt_eff == 2'd0)
					held_q <= {data_byte, 8'h00};
				else
					held_q <= {held_q[15:8], data_byte};
			end
		end
	end

endmodule

// ===== src/b64e_group_fifo.sv =====
// Short group queue between the front and the back.
`timescale 1ns / 1ps
module b64e_group_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  b64e_pkg::group_entry_t wr_entry,
	input  logic                   rd_en,
	output b64e_pkg::group_entry_t rd_entry,
	output logic                   fifo_full,
	output logic                   fifo_empty
);
	import b64e_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W2 = $clog2(DEPTH + 1);

	group_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W2-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign fifo_full  = (count_q == CNT_W2'(DEPTH));
	assign fifo_empty = (count_q == '0);
	assign do_wr      = wr_en && !fifo_full;
	assign do_rd      = rd_en && !fifo_empty;
	assign rd_entry   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_rd)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ===== src/b64e_back.sv =====
// Back end: walks a group's four sextets into the result register.
`timescale 1ns / 1ps
module b64e_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  b64e_pkg::group_entry_t      grp_entry,
	input  logic                        grp_empty,
	output logic                        grp_rd,
	input  logic                        pop,
	output logic                        empty,
	output logic [b64e_pkg::CHAR_W-1:0] char_code,
	output logic                        final_char
);
	import b64e_pkg::*;

	logic               out_v_q;
	logic [CHAR_W-1:0]  char_q;
	logic               fin_q;
	logic [1:0]         k_q;
	logic               advance;
	logic               take;
	logic [5:0]         sextet;
	logic [CHAR_W-1:0]  next_char;

	assign advance = !out_v_q || pop;
	assign take    = advance && !grp_empty;
	assign grp_rd  = take && (k_q == 2'd3);

	always_comb begin
		case (k_q)
			2'd0:    sextet = grp_entry.group[23:18];
			2'd1:    sextet = grp_entry.group[17:12];
			2'd2:    sextet = grp_entry.group[11:6];
			default: sextet = grp_entry.group[5:0];
		endcase
		next_char = (k_q <= grp_entry.n_real) ? sextet_char(sextet) : PAD_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (advance)
				out_v_q <= !grp_empty;
			if (take)
				k_q <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= next_char;
			fin_q  <= grp_entry.last && (k_q == 2'd3);
		end
	end

	assign empty      = !out_v_q;
	assign char_code  = char_q;
	assign final_char = fin_q;

endmodule

// ===== test/base64_stream_encoder_top_tb.sv =====
// Testbench for base64_stream_encoder_top: directed and random messages checked against a predictor.
`timescale 1ns / 1ps
module base64_stream_encoder_top_tb;
	import b64e_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned ITEMS_PER_PASS = 90;
	localparam int unsigned DRAIN_CYCLES   = 20;

	// One raw byte of a message as it waits for its transfer.
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} msg_byte_t;

	// One encoded character as the predictor expects it.
	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} enc_char_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                final_byte = 1'b0;
	logic                empty;
	logic                pop = 1'b0;
	logic [CHAR_W-1:0]   char_code;
	logic                final_char;

	msg_byte_t   byte_backlog[$];   // bytes the driver has yet to present
	enc_char_t   char_forecast[$];  // characters the block still owes
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// Predictor state: bytes of the open group.
	logic [1:0]  held_cnt = '0;
	logic [15:0] held_bytes = '0;

	base64_stream_encoder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.char_code  (char_code),
		.final_char (final_char)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Look the six-bit value up in the standard alphabet.
	function automatic logic [CHAR_W-1:0] b64_letter(input logic [5:0] v);
		string alpha;
		byte   letter;
		alpha = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
			"0123456789+/"};
		letter = alpha[v];
		return letter[CHAR_W-1:0];
	endfunction

	// Advance the predictor by one transferred byte and queue the characters it yields.
	task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [23:0] grp;
		int unsigned n_real;
		enc_char_t ch;
		if (!fin && held_cnt < 2) begin
			// Hold the byte; nothing leaves until the group closes.
			if (held_cnt == 0)
				held_bytes = {b, 8'h00};
			else
				held_bytes[7:0] = b;
			held_cnt = held_cnt + 2'd1;
		end else begin
			// Place the new byte behind the held ones; zero-fill the tail.
			case (held_cnt)
				2'd0: grp = {b, 16'h0000};
				2'd1: grp = {held_bytes[15:8], b, 8'h00};
				default: grp = {held_bytes, b};
			endcase
			n_real = held_cnt + 1;
			for (int k = 0; k < 4; k++) begin
				ch.code = (k <= n_real) ? b64_letter(grp[23 - 6 * k -: 6]) : PAD_CHAR;
				ch.last = fin && (k == 3);
				char_forecast.push_back(ch);
			end
			held_cnt = '0;
			held_bytes = '0;
		end
	endtask

	// Queue one message of the given bytes; the last one carries the final flag.
	task automatic queue_message(input logic [BYTE_W-1:0] bytes[$]);
		msg_byte_t mb;
		foreach (bytes[i]) begin
			mb.data = bytes[i];
			mb.last = (i == bytes.size() - 1);
			byte_backlog.push_back(mb);
		end
	endtask

	// Queue random messages until the pass holds enough bytes.
	task automatic queue_random_pass(input int unsigned n_items);
		logic [BYTE_W-1:0] bytes[$];
		int unsigned queued;
		int unsigned len;
		queued = 0;
		while (queued < n_items) begin
			bytes.delete();
			// Mostly short messages so every tail length shows up often.
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(7))
					0: bytes.push_back(8'h00);
					1: bytes.push_back(8'hff);
					default: bytes.push_back(BYTE_W'($urandom_range(255)));
				endcase
			end
			queue_message(bytes);
			queued += len;
		end
	endtask

	// Hold until every queued byte is transferred and every character has come back.
	task automatic wait_drained();
		while (byte_backlog.size() != 0 || push || char_forecast.size() != 0)
			@(posedge clk);
	endtask

	// Driver: take the transfer into the predictor, then present the next byte or idle.
	always @(posedge clk) begin
		msg_byte_t mb;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				encode_byte(data_byte, final_byte);
			// The port is free when nothing is offered or the offer just went through.
			if (!push || !full) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					mb = byte_backlog.pop_front();
					push <= 1'b1;
					data_byte <= mb.data;
					final_byte <= mb.last;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each transferred character with the oldest expectation.
	always @(posedge clk) begin
		enc_char_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (char_forecast.size() == 0) begin
					$error("unexpected character: char_code %0d final_char %0b",
						char_code, final_char);
					error_count++;
				end else begin
					want = char_forecast.pop_front();
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, actual %0d", want.code, char_code);
						error_count++;
					end
					if (final_char !== want.last) begin
						$error("final_char: expected %0b, actual %0b", want.last, final_char);
						error_count++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("base64_stream_encoder_top test failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed messages: every tail length, all-zero and all-one bytes,
		// and groups that reach '+', '/' and the digits.
		queue_message('{8'h00});
		queue_message('{8'hff, 8'hff});
		queue_message('{8'h00, 8'h00, 8'h00});
		queue_message('{8'hff, 8'hff, 8'hff, 8'hf8});
		queue_message('{8'hd3, 8'h5d, 8'hb7, 8'he3, 8'h9e});
		queue_message('{8'hfb, 8'hef, 8'hbe, 8'h12, 8'h34, 8'h56});
		wait_drained();

		// Random passes under each mix of sender gaps and receiver stalls.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_pass(ITEMS_PER_PASS);
		wait_drained();

		send_idle_pct = 64;
		recv_stall_pct = 0;
		queue_random_pass(ITEMS_PER_PASS);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 64;
		queue_random_pass(ITEMS_PER_PASS);
		wait_drained();

		send_idle_pct = 31;
		recv_stall_pct = 31;
		queue_random_pass(ITEMS_PER_PASS);
		wait_drained();

		// Let any stray character surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("base64_stream_encoder_top test passed");
		else
			$display("base64_stream_encoder_top test failed");
		$finish;
	end

endmodule

// ===== base64_stream_encoder_top.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_group_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder_top.sv
test/base64_stream_encoder_top_tb.sv
